// ----- rtl/core/cfj_pkg.sv -----
// ----------------------------------------------------------------------------
// cfj_pkg: shared types and constants of the force-to-torque block
// Field widths, fixed-point constants, the CORDIC angle table and the
// records that travel down the cell chains.
// ----------------------------------------------------------------------------
package cfj_pkg;

  // Field widths
  localparam int FW     = 24;   // Cartesian force, Q15.8
  localparam int AW     = 16;   // joint angle, Q2.13
  localparam int VW     = 16;   // joint speed, Q4.11
  localparam int TW     = 16;   // joint torque, Q.8
  localparam int LW     = 16;   // link length, Q0.16
  localparam int MFW    = 18;   // force limit
  localparam int MTW    = 15;   // torque limit and Coulomb torques
  localparam int VSW    = 16;   // viscous gains
  localparam int CFG_W  = 18;   // widest register
  localparam int CFG_AW = 3;

  // Internal widths
  localparam int SUM_W   = 2 * FW;        // fx^2 + fy^2
  localparam int ROOT_W  = FW;            // floor square root of the sum
  localparam int QW      = MFW;           // scaled force magnitude
  localparam int PROD_W  = FW + MFW;      // |f| * max_force
  localparam int WRAP_W  = 40;            // unwrapped angles in Q.30
  localparam int ANG_W   = 33;            // folded angles in Q.30
  localparam int CW      = 33;            // CORDIC x and y in Q.30
  localparam int ATAN_N  = 24;
  localparam int RATIO_W = 16;
  localparam int RSW     = RATIO_W + 1;

  localparam int FRONT_LAT = 8;
  localparam int BACK_LAT  = 6;

  localparam int PARALLEL_RATIO_Q12 = 4096;
  localparam int CORDIC_STAGES_DEF  = 16;

  localparam logic signed [WRAP_W-1:0] PI_Q30      = 40'sd3373259426;
  localparam logic signed [WRAP_W-1:0] TWO_PI_Q30  = 40'sd6746518852;
  localparam logic signed [WRAP_W-1:0] HALF_PI_Q30 = 40'sd1686629713;
  // Offset that makes every reachable angle non-negative before reduction.
  localparam logic signed [WRAP_W-1:0] WRAP_OFS    = PI_Q30 + (TWO_PI_Q30 <<< 3);
  localparam logic signed [CW-1:0]     CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [VW-1:0]     DEAD_BAND   = 16'sd61;

  typedef enum logic [CFG_AW-1:0] {
    CFG_LINK1, CFG_LINK2, CFG_MAX_FORCE, CFG_MAX_TORQUE,
    CFG_COUL1, CFG_COUL2, CFG_VISC1, CFG_VISC2
  } cfg_idx_t;

  typedef struct packed {
    logic                     cal;
    logic                     fric;
    logic                     flim;
    logic signed [FW-1:0]     fx;
    logic signed [FW-1:0]     fy;
    logic signed [VW-1:0]     v1;
    logic signed [VW-1:0]     v2;
    logic signed [ANG_W-1:0]  ang1;
    logic signed [ANG_W-1:0]  ang12;
    logic                     neg1;
    logic                     neg12;
    logic [PROD_W-1:0]        px;
    logic [PROD_W-1:0]        py;
  } side_t;

  typedef struct packed {
    logic signed [CW-1:0]    x;
    logic signed [CW-1:0]    y;
    logic signed [ANG_W-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [LW-1:0]  link1;
    logic [LW-1:0]  link2;
    logic [MTW-1:0] max_torque;
    logic [MTW-1:0] coul1;
    logic [MTW-1:0] coul2;
    logic [VSW-1:0] vis1;
    logic [VSW-1:0] vis2;
  } torque_cfg_t;

  // atan(2^-i) in Q.30, truncated.
  function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
    case (i)
      0:       return 33'sd843314856;
      1:       return 33'sd497837829;
      2:       return 33'sd263043836;
      3:       return 33'sd133525158;
      4:       return 33'sd67021686;
      5:       return 33'sd33543515;
      6:       return 33'sd16775850;
      7:       return 33'sd8388437;
      8:       return 33'sd4194282;
      9:       return 33'sd2097149;
      10:      return 33'sd1048575;
      11:      return 33'sd524287;
      12:      return 33'sd262143;
      13:      return 33'sd131071;
      14:      return 33'sd65535;
      15:      return 33'sd32767;
      16:      return 33'sd16383;
      17:      return 33'sd8191;
      18:      return 33'sd4095;
      19:      return 33'sd2047;
      20:      return 33'sd1023;
      21:      return 33'sd511;
      22:      return 33'sd255;
      23:      return 33'sd127;
      default: return '0;
    endcase
  endfunction

  function automatic int cordic_used(input int s);
    return (s < ATAN_N) ? s : ATAN_N;
  endfunction

  function automatic int cfj_latency(input int s);
    return FRONT_LAT + ROOT_W + QW + cordic_used(s) + BACK_LAT;
  endfunction

endpackage

// ----- rtl/core/cfj_front.sv -----
// ----------------------------------------------------------------------------
// cfj_front: input stages
// Squares and force products, the limit compare, and reduction of both
// joint angles into [-pi/2, pi/2] with a sign flag.
// ----------------------------------------------------------------------------
module cfj_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_i,
  input  logic signed [cfj_pkg::FW-1:0] fx_i,
  input  logic signed [cfj_pkg::FW-1:0] fy_i,
  input  logic signed [cfj_pkg::AW-1:0] a1_i,
  input  logic signed [cfj_pkg::AW-1:0] a2_i,
  input  logic signed [cfj_pkg::VW-1:0] v1_i,
  input  logic signed [cfj_pkg::VW-1:0] v2_i,
  input  logic                          fric_i,
  input  logic                          cal_i,
  input  logic [cfj_pkg::MFW-1:0]       max_force_i,
  output logic                          vld_o,
  output cfj_pkg::side_t                side_o,
  output logic [cfj_pkg::SUM_W-1:0]     sum_o
);
  import cfj_pkg::*;

  localparam logic signed [RSW-1:0] RATIO_S = RSW'(PARALLEL_RATIO_Q12);

  function automatic logic [ANG_W:0] fold_angle(input logic signed [WRAP_W-1:0] u);
    logic signed [WRAP_W-1:0] t;
    t = u - PI_Q30;
    if (t > HALF_PI_Q30) return {1'b1, ANG_W'(t - PI_Q30)};
    if (t < -HALF_PI_Q30) return {1'b1, ANG_W'(t + PI_Q30)};
    return {1'b0, ANG_W'(t)};
  endfunction

  logic [FRONT_LAT-1:0] vld_r;

  // Stage 1: captured inputs
  logic signed [FW-1:0] fx1_r, fy1_r;
  logic signed [AW-1:0] a1_1_r, a2_1_r;
  logic signed [VW-1:0] v1_1_r, v2_1_r;
  logic                 fric1_r, cal1_r;

  // Stage 2: products
  logic [FW-1:0]            magx, magy;
  logic [SUM_W-1:0]         sqx2_r, sqy2_r;
  logic [PROD_W-1:0]        px2_r, py2_r;
  logic [2*MFW-1:0]         lim2_r;
  logic signed [WRAP_W-1:0] t1_2_r;
  logic signed [AW+RSW-1:0] r2_2_r;
  logic signed [FW-1:0]     fx2_r, fy2_r;
  logic signed [VW-1:0]     v1_2_r, v2_2_r;
  logic                     fric2_r, cal2_r;

  // Stage 3 onward: record, sum and angles being reduced
  side_t                    sd_r  [0:5];
  logic [SUM_W-1:0]         sm_r  [0:5];
  logic signed [WRAP_W-1:0] u1_r  [0:4];
  logic signed [WRAP_W-1:0] u12_r [0:4];
  logic [ANG_W:0]           f1, f12;
  side_t                    sd0, sd5;

  assign magx = fx1_r[FW-1] ? -fx1_r : fx1_r;
  assign magy = fy1_r[FW-1] ? -fy1_r : fy1_r;

  always_comb begin
    sd0      = '0;
    sd0.cal  = cal2_r;
    sd0.fric = fric2_r;
    sd0.flim = (sqx2_r + sqy2_r) > SUM_W'(lim2_r);
    sd0.fx   = fx2_r;
    sd0.fy   = fy2_r;
    sd0.v1   = v1_2_r;
    sd0.v2   = v2_2_r;
    sd0.px   = px2_r;
    sd0.py   = py2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[FRONT_LAT-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    fx1_r   <= fx_i;
    fy1_r   <= fy_i;
    a1_1_r  <= a1_i;
    a2_1_r  <= a2_i;
    v1_1_r  <= v1_i;
    v2_1_r  <= v2_i;
    fric1_r <= fric_i;
    cal1_r  <= cal_i;

    sqx2_r  <= magx * magx;
    sqy2_r  <= magy * magy;
    px2_r   <= magx * max_force_i;
    py2_r   <= magy * max_force_i;
    lim2_r  <= max_force_i * max_force_i;
    t1_2_r  <= WRAP_W'(a1_1_r) <<< 17;
    r2_2_r  <= a2_1_r * RATIO_S;
    fx2_r   <= fx1_r;
    fy2_r   <= fy1_r;
    v1_2_r  <= v1_1_r;
    v2_2_r  <= v2_1_r;
    fric2_r <= fric1_r;
    cal2_r  <= cal1_r;

    sm_r[0]  <= sqx2_r + sqy2_r;
    sd_r[0]  <= sd0;
    u1_r[0]  <= t1_2_r + WRAP_OFS;
    u12_r[0] <= t1_2_r + (WRAP_W'(r2_2_r) <<< 5) + WRAP_OFS;
  end

  // Four conditional subtractions of 16, 8, 4 and 2 pi reduce into [0, 2 pi).
  for (genvar j = 0; j < 4; j++) begin : g_wrap
    localparam logic signed [WRAP_W-1:0] STEP = TWO_PI_Q30 <<< (3 - j);
    always_ff @(posedge clk) begin
      sd_r[j+1]  <= sd_r[j];
      sm_r[j+1]  <= sm_r[j];
      u1_r[j+1]  <= (u1_r[j] >= STEP) ? u1_r[j] - STEP : u1_r[j];
      u12_r[j+1] <= (u12_r[j] >= STEP) ? u12_r[j] - STEP : u12_r[j];
    end
  end

  assign f1  = fold_angle(u1_r[4]);
  assign f12 = fold_angle(u12_r[4]);

  always_comb begin
    sd5       = sd_r[4];
    sd5.neg1  = f1[ANG_W];
    sd5.ang1  = f1[ANG_W-1:0];
    sd5.neg12 = f12[ANG_W];
    sd5.ang12 = f12[ANG_W-1:0];
  end

  always_ff @(posedge clk) begin
    sm_r[5] <= sm_r[4];
    sd_r[5] <= sd5;
  end

  assign vld_o  = vld_r[FRONT_LAT-1];
  assign side_o = sd_r[5];
  assign sum_o  = sm_r[5];

endmodule

// ----- rtl/core/cfj_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// cfj_sqrt_cell: one digit of the square root chain
// Decides one root bit of the force magnitude and passes the record on.
// ----------------------------------------------------------------------------
module cfj_sqrt_cell #(
  parameter int LVL = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      vld_i,
  input  cfj_pkg::side_t            side_i,
  input  logic [cfj_pkg::SUM_W-1:0] v_i,
  input  logic [cfj_pkg::SUM_W-1:0] res_i,
  output logic                      vld_o,
  output cfj_pkg::side_t            side_o,
  output logic [cfj_pkg::SUM_W-1:0] v_o,
  output logic [cfj_pkg::SUM_W-1:0] res_o
);
  import cfj_pkg::*;

  localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * LVL);

  logic [SUM_W-1:0] trial, v_nxt, res_nxt;
  logic             vld_r;
  side_t            side_r;
  logic [SUM_W-1:0] v_r, res_r;

  always_comb begin
    trial = res_i + BIT;
    if (v_i >= trial) begin
      v_nxt   = v_i - trial;
      res_nxt = (res_i >> 1) + BIT;
    end else begin
      v_nxt   = v_i;
      res_nxt = res_i >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    side_r <= side_i;
    v_r    <= v_nxt;
    res_r  <= res_nxt;
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign v_o    = v_r;
  assign res_o  = res_r;

endmodule

// ----- rtl/core/cfj_div_cell.sv -----
// ----------------------------------------------------------------------------
// cfj_div_cell: one quotient bit of the force scaling divider
// Both force components are divided by the magnitude side by side.
// ----------------------------------------------------------------------------
module cfj_div_cell #(
  parameter int SH = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       vld_i,
  input  cfj_pkg::side_t             side_i,
  input  logic [cfj_pkg::ROOT_W-1:0] n_i,
  input  logic [cfj_pkg::PROD_W-1:0] rx_i,
  input  logic [cfj_pkg::PROD_W-1:0] ry_i,
  input  logic [cfj_pkg::QW-1:0]     qx_i,
  input  logic [cfj_pkg::QW-1:0]     qy_i,
  output logic                       vld_o,
  output cfj_pkg::side_t             side_o,
  output logic [cfj_pkg::ROOT_W-1:0] n_o,
  output logic [cfj_pkg::PROD_W-1:0] rx_o,
  output logic [cfj_pkg::PROD_W-1:0] ry_o,
  output logic [cfj_pkg::QW-1:0]     qx_o,
  output logic [cfj_pkg::QW-1:0]     qy_o
);
  import cfj_pkg::*;

  localparam logic [QW-1:0] QBIT = QW'(1) << SH;

  logic [PROD_W-1:0] d;
  logic              vld_r;
  side_t             side_r;
  logic [ROOT_W-1:0] n_r;
  logic [PROD_W-1:0] rx_r, ry_r;
  logic [QW-1:0]     qx_r, qy_r;

  assign d = PROD_W'(n_i) << SH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    side_r <= side_i;
    n_r    <= n_i;
    rx_r   <= (rx_i >= d) ? rx_i - d : rx_i;
    qx_r   <= (rx_i >= d) ? (qx_i | QBIT) : qx_i;
    ry_r   <= (ry_i >= d) ? ry_i - d : ry_i;
    qy_r   <= (ry_i >= d) ? (qy_i | QBIT) : qy_i;
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign n_o    = n_r;
  assign rx_o   = rx_r;
  assign ry_o   = ry_r;
  assign qx_o   = qx_r;
  assign qy_o   = qy_r;

endmodule

// ----- rtl/core/cfj_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// cfj_cordic_cell: one rotation step for both joint angles
// Rotation mode: the residual angle's sign picks the direction.
// ----------------------------------------------------------------------------
module cfj_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vld_i,
  input  cfj_pkg::side_t   side_i,
  input  cfj_pkg::cordic_t c1_i,
  input  cfj_pkg::cordic_t c12_i,
  output logic             vld_o,
  output cfj_pkg::side_t   side_o,
  output cfj_pkg::cordic_t c1_o,
  output cfj_pkg::cordic_t c12_o
);
  import cfj_pkg::*;

  localparam logic signed [ANG_W-1:0] ATAN = atan_q30(IDX);

  function automatic cordic_t rotate(input cordic_t c);
    cordic_t r;
    if (c.z >= 0) begin
      r.x = c.x - (c.y >>> IDX);
      r.y = c.y + (c.x >>> IDX);
      r.z = c.z - ATAN;
    end else begin
      r.x = c.x + (c.y >>> IDX);
      r.y = c.y - (c.x >>> IDX);
      r.z = c.z + ATAN;
    end
    return r;
  endfunction

  logic    vld_r;
  side_t   side_r;
  cordic_t c1_r, c12_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    side_r <= side_i;
    c1_r   <= rotate(c1_i);
    c12_r  <= rotate(c12_i);
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign c1_o   = c1_r;
  assign c12_o  = c12_r;

endmodule

// ----- rtl/core/cfj_torque.sv -----
// ----------------------------------------------------------------------------
// cfj_torque: Jacobian transpose, friction and clamp
// Six stages from sin/cos and the limited force to the output register.
// ----------------------------------------------------------------------------
module cfj_torque (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_i,
  input  cfj_pkg::side_t                side_i,
  input  cfj_pkg::cordic_t              c1_i,
  input  cfj_pkg::cordic_t              c12_i,
  input  cfj_pkg::torque_cfg_t          cfg_i,
  output logic                          vld_o,
  output logic signed [cfj_pkg::TW-1:0] torque1_o,
  output logic signed [cfj_pkg::TW-1:0] torque2_o,
  output logic                          status_o,
  output logic                          flim_o,
  output logic [1:0]                    tlim_o
);
  import cfj_pkg::*;

  localparam int PW    = CW + FW;
  localparam int DW    = PW + 1;
  localparam int GW    = DW - 14;
  localparam int MW    = GW + LW + 1;
  localparam int SW    = MW + 1;
  localparam int TAU_W = SW - 32;
  localparam int VFW   = VSW + 1 + VW;
  localparam int INC_W = VFW - 11 + 1;
  localparam int TFW   = TAU_W + 2;

  function automatic logic signed [INC_W-1:0] fric_inc(input logic signed [VW-1:0] v,
                                                       input logic [MTW-1:0] coul,
                                                       input logic signed [VFW-1:0] vf);
    logic signed [INC_W-1:0] c, visc;
    c    = INC_W'($signed({1'b0, coul}));
    visc = INC_W'(vf >>> 11);
    if (v > DEAD_BAND) return c + visc;
    if (v < -DEAD_BAND) return visc - c;
    return '0;
  endfunction

  function automatic logic [TW:0] clamp(input logic signed [TFW-1:0] t,
                                        input logic [MTW-1:0] m);
    logic signed [TFW-1:0] lim;
    lim = TFW'($signed({1'b0, m}));
    if (t > lim) return {1'b1, TW'(lim)};
    if (t < -lim) return {1'b1, TW'(-lim)};
    return {1'b0, TW'(t)};
  endfunction

  logic [BACK_LAT-1:0] vld_r;
  side_t               sd_r [1:5];

  logic signed [PW-1:0]    pa1_r, pb1_r, pa12_r, pb12_r;
  logic signed [DW-1:0]    d1, d12, dn1, dn12;
  logic signed [GW-1:0]    g1_r, g12_r;
  logic signed [VFW-1:0]   vf1_r, vf2_r, vf1_3_r, vf2_3_r;
  logic signed [MW-1:0]    m1_r, m2_r;
  logic signed [TAU_W-1:0] tau1_r, tau2_r;
  logic signed [INC_W-1:0] inc1_r, inc2_r;
  logic signed [TFW-1:0]   tf1_r, tf2_r;
  logic [TW:0]             k1, k2;
  logic signed [TW-1:0]    torque1_r, torque2_r;
  logic                    status_r, flim_r;
  logic [1:0]              tlim_r;

  assign d1   = DW'(pa1_r) - DW'(pb1_r);
  assign d12  = DW'(pa12_r) - DW'(pb12_r);
  assign dn1  = sd_r[1].neg1 ? -d1 : d1;
  assign dn12 = sd_r[1].neg12 ? -d12 : d12;
  assign k1   = clamp(tf1_r, cfg_i.max_torque);
  assign k2   = clamp(tf2_r, cfg_i.max_torque);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[BACK_LAT-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    // cos * fy and sin * fx for both angles
    sd_r[1] <= side_i;
    pa1_r   <= c1_i.x * side_i.fy;
    pb1_r   <= c1_i.y * side_i.fx;
    pa12_r  <= c12_i.x * side_i.fy;
    pb12_r  <= c12_i.y * side_i.fx;

    sd_r[2] <= sd_r[1];
    g1_r    <= GW'(dn1 >>> 14);
    g12_r   <= GW'(dn12 >>> 14);
    vf1_r   <= $signed({1'b0, cfg_i.vis1}) * sd_r[1].v1;
    vf2_r   <= $signed({1'b0, cfg_i.vis2}) * sd_r[1].v2;

    sd_r[3] <= sd_r[2];
    m1_r    <= $signed({1'b0, cfg_i.link1}) * g1_r;
    m2_r    <= $signed({1'b0, cfg_i.link2}) * g12_r;
    vf1_3_r <= vf1_r;
    vf2_3_r <= vf2_r;

    sd_r[4] <= sd_r[3];
    tau1_r  <= TAU_W'((SW'(m1_r) + SW'(m2_r)) >>> 32);
    tau2_r  <= TAU_W'(m2_r >>> 32);
    inc1_r  <= fric_inc(sd_r[3].v1, cfg_i.coul1, vf1_3_r);
    inc2_r  <= fric_inc(sd_r[3].v2, cfg_i.coul2, vf2_3_r);

    sd_r[5] <= sd_r[4];
    tf1_r   <= TFW'(tau1_r) + (sd_r[4].fric ? TFW'(inc1_r) : TFW'(0));
    tf2_r   <= TFW'(tau2_r) + (sd_r[4].fric ? TFW'(inc2_r) : TFW'(0));

    // An uncalibrated arm gets zero torques, status high and no limit flags.
    if (sd_r[5].cal) begin
      torque1_r <= k1[TW-1:0];
      torque2_r <= k2[TW-1:0];
      status_r  <= 1'b0;
      flim_r    <= sd_r[5].flim;
      tlim_r    <= {k2[TW], k1[TW]};
    end else begin
      torque1_r <= '0;
      torque2_r <= '0;
      status_r  <= 1'b1;
      flim_r    <= 1'b0;
      tlim_r    <= '0;
    end
  end

  assign vld_o     = vld_r[BACK_LAT-1];
  assign torque1_o = torque1_r;
  assign torque2_o = torque2_r;
  assign status_o  = status_r;
  assign flim_o    = flim_r;
  assign tlim_o    = tlim_r;

endmodule

// ----- rtl/core/cartesian_force_to_joint_torque.sv -----
// ----------------------------------------------------------------------------
// cartesian_force_to_joint_torque: planar two-link force to joint torques
// Force limit, Jacobian transpose with CORDIC sin/cos, friction and clamp.
// ----------------------------------------------------------------------------
// A new transaction is taken in every clock cycle; busy never rises. Each
// result appears on the out_ ports for one cycle under out_valid, exactly
// 56 + CORDIC_STAGES cycles (72 by default) after its start, and must be
// taken then since the receiver cannot stall the block. The latency is set
// by the cell chains: 24 square-root cells, 18 divider cells and one CORDIC
// cell per stage (at most 24), plus 8 input and 6 output stages. Registers
// may be written only while no transaction is in flight.
module cartesian_force_to_joint_torque #(
  parameter int CORDIC_STAGES = cfj_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [cfj_pkg::FW-1:0]     in_force_x,
  input  logic signed [cfj_pkg::FW-1:0]     in_force_y,
  input  logic signed [cfj_pkg::AW-1:0]     in_angle_joint1,
  input  logic signed [cfj_pkg::AW-1:0]     in_angle_joint2,
  input  logic signed [cfj_pkg::VW-1:0]     in_speed_joint1,
  input  logic signed [cfj_pkg::VW-1:0]     in_speed_joint2,
  input  logic                              in_friction_on,
  input  logic                              in_is_calibrated,
  input  logic                              cfg_we,
  input  logic [cfj_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [cfj_pkg::CFG_W-1:0]         cfg_data,
  output logic                              out_valid,
  output logic signed [cfj_pkg::TW-1:0]     out_torque_joint1,
  output logic signed [cfj_pkg::TW-1:0]     out_torque_joint2,
  output logic                              out_status,
  output logic                              out_force_limited,
  output logic [1:0]                        out_torque_limited
);
  import cfj_pkg::*;

  localparam int NSTG = cordic_used(CORDIC_STAGES);

  torque_cfg_t   tcfg_r;
  logic [MFW-1:0] max_force_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcfg_r      <= '0;
      max_force_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_LINK1:      tcfg_r.link1      <= cfg_data[LW-1:0];
        CFG_LINK2:      tcfg_r.link2      <= cfg_data[LW-1:0];
        CFG_MAX_FORCE:  max_force_r       <= cfg_data[MFW-1:0];
        CFG_MAX_TORQUE: tcfg_r.max_torque <= cfg_data[MTW-1:0];
        CFG_COUL1:      tcfg_r.coul1      <= cfg_data[MTW-1:0];
        CFG_COUL2:      tcfg_r.coul2      <= cfg_data[MTW-1:0];
        CFG_VISC1:      tcfg_r.vis1       <= cfg_data[VSW-1:0];
        CFG_VISC2:      tcfg_r.vis2       <= cfg_data[VSW-1:0];
        default:        tcfg_r            <= tcfg_r;
      endcase
    end
  end

  assign busy = 1'b0;

  // Square-root chain
  logic             sq_vld  [0:ROOT_W];
  side_t            sq_side [0:ROOT_W];
  logic [SUM_W-1:0] sq_v    [0:ROOT_W];
  logic [SUM_W-1:0] sq_res  [0:ROOT_W];

  cfj_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .vld_i       (start && !busy),
    .fx_i        (in_force_x),
    .fy_i        (in_force_y),
    .a1_i        (in_angle_joint1),
    .a2_i        (in_angle_joint2),
    .v1_i        (in_speed_joint1),
    .v2_i        (in_speed_joint2),
    .fric_i      (in_friction_on),
    .cal_i       (in_is_calibrated),
    .max_force_i (max_force_r),
    .vld_o       (sq_vld[0]),
    .side_o      (sq_side[0]),
    .sum_o       (sq_v[0])
  );
  assign sq_res[0] = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    cfj_sqrt_cell #(.LVL(ROOT_W - 1 - k)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (sq_vld[k]),
      .side_i (sq_side[k]),
      .v_i    (sq_v[k]),
      .res_i  (sq_res[k]),
      .vld_o  (sq_vld[k+1]),
      .side_o (sq_side[k+1]),
      .v_o    (sq_v[k+1]),
      .res_o  (sq_res[k+1])
    );
  end

  // Divider chain
  logic              dv_vld  [0:QW];
  side_t             dv_side [0:QW];
  logic [ROOT_W-1:0] dv_n    [0:QW];
  logic [PROD_W-1:0] dv_rx   [0:QW];
  logic [PROD_W-1:0] dv_ry   [0:QW];
  logic [QW-1:0]     dv_qx   [0:QW];
  logic [QW-1:0]     dv_qy   [0:QW];

  assign dv_vld[0]  = sq_vld[ROOT_W];
  assign dv_side[0] = sq_side[ROOT_W];
  assign dv_n[0]    = sq_res[ROOT_W][ROOT_W-1:0];
  assign dv_rx[0]   = sq_side[ROOT_W].px;
  assign dv_ry[0]   = sq_side[ROOT_W].py;
  assign dv_qx[0]   = '0;
  assign dv_qy[0]   = '0;

  for (genvar k = 0; k < QW; k++) begin : g_div
    cfj_div_cell #(.SH(QW - 1 - k)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (dv_vld[k]),
      .side_i (dv_side[k]),
      .n_i    (dv_n[k]),
      .rx_i   (dv_rx[k]),
      .ry_i   (dv_ry[k]),
      .qx_i   (dv_qx[k]),
      .qy_i   (dv_qy[k]),
      .vld_o  (dv_vld[k+1]),
      .side_o (dv_side[k+1]),
      .n_o    (dv_n[k+1]),
      .rx_o   (dv_rx[k+1]),
      .ry_o   (dv_ry[k+1]),
      .qx_o   (dv_qx[k+1]),
      .qy_o   (dv_qy[k+1])
    );
  end

  // CORDIC chain; the limited force replaces the request when scaled.
  logic    cr_vld  [0:NSTG];
  side_t   cr_side [0:NSTG];
  cordic_t cr_c1   [0:NSTG];
  cordic_t cr_c12  [0:NSTG];
  side_t   lim_side;

  always_comb begin
    lim_side = dv_side[QW];
    if (dv_side[QW].flim) begin
      lim_side.fx = dv_side[QW].fx[FW-1] ? -$signed(FW'(dv_qx[QW])) : $signed(FW'(dv_qx[QW]));
      lim_side.fy = dv_side[QW].fy[FW-1] ? -$signed(FW'(dv_qy[QW])) : $signed(FW'(dv_qy[QW]));
    end
  end

  assign cr_vld[0]   = dv_vld[QW];
  assign cr_side[0]  = lim_side;
  assign cr_c1[0].x  = CORDIC_GAIN;
  assign cr_c1[0].y  = '0;
  assign cr_c1[0].z  = dv_side[QW].ang1;
  assign cr_c12[0].x = CORDIC_GAIN;
  assign cr_c12[0].y = '0;
  assign cr_c12[0].z = dv_side[QW].ang12;

  for (genvar k = 0; k < NSTG; k++) begin : g_cordic
    cfj_cordic_cell #(.IDX(k)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (cr_vld[k]),
      .side_i (cr_side[k]),
      .c1_i   (cr_c1[k]),
      .c12_i  (cr_c12[k]),
      .vld_o  (cr_vld[k+1]),
      .side_o (cr_side[k+1]),
      .c1_o   (cr_c1[k+1]),
      .c12_o  (cr_c12[k+1])
    );
  end

  cfj_torque u_torque (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld_i     (cr_vld[NSTG]),
    .side_i    (cr_side[NSTG]),
    .c1_i      (cr_c1[NSTG]),
    .c12_i     (cr_c12[NSTG]),
    .cfg_i     (tcfg_r),
    .vld_o     (out_valid),
    .torque1_o (out_torque_joint1),
    .torque2_o (out_torque_joint2),
    .status_o  (out_status),
    .flim_o    (out_force_limited),
    .tlim_o    (out_torque_limited)
  );

endmodule

// ----- rtl/core/cfj_checker.sv -----
// ----------------------------------------------------------------------------
// cfj_checker: port-level checks of the force-to-torque block
// Fixed latency, the uncalibrated result and the torque clamp.
// ----------------------------------------------------------------------------
module cfj_checker #(
  parameter int LAT = 72
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          cfg_we,
  input logic [cfj_pkg::CFG_AW-1:0]    cfg_addr,
  input logic [cfj_pkg::CFG_W-1:0]     cfg_data,
  input logic                          out_valid,
  input logic signed [cfj_pkg::TW-1:0] out_torque_joint1,
  input logic signed [cfj_pkg::TW-1:0] out_torque_joint2,
  input logic                          out_status,
  input logic                          out_force_limited,
  input logic [1:0]                    out_torque_limited
);
  import cfj_pkg::*;

  localparam int CNT_W = $clog2(LAT + 1);

  logic [CNT_W-1:0]     warm_r;
  logic signed [TW-1:0] mt_r;
  logic                 warm;

  // Warm-up counter and shadow copy of the torque limit, tracked from the write port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_r <= '0;
      mt_r   <= '0;
    end else begin
      if (warm_r != CNT_W'(LAT)) warm_r <= warm_r + 1'b1;
      if (cfg_we && (cfg_idx_t'(cfg_addr) == CFG_MAX_TORQUE)) begin
        mt_r <= $signed(TW'(cfg_data[MTW-1:0]));
      end
    end
  end

  assign warm = (warm_r == CNT_W'(LAT));

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    warm |-> (out_valid == $past(start && !busy, LAT)))
    else $error("result strobe does not follow its transaction at fixed latency");

  a_uncal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_torque_joint1 == 0 && out_torque_joint2 == 0 &&
                                   !out_force_limited && out_torque_limited == 2'b00))
    else $error("uncalibrated result carries torque or flags");

  a_clamp1: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_status) |->
      (out_torque_joint1 <= mt_r && out_torque_joint1 >= -mt_r &&
       (!out_torque_limited[0] || out_torque_joint1 == mt_r || out_torque_joint1 == -mt_r)))
    else $error("joint one torque outside its clamp");

  a_clamp2: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_status) |->
      (out_torque_joint2 <= mt_r && out_torque_joint2 >= -mt_r &&
       (!out_torque_limited[1] || out_torque_joint2 == mt_r || out_torque_joint2 == -mt_r)))
    else $error("joint two torque outside its clamp");

endmodule

bind cartesian_force_to_joint_torque cfj_checker #(
  .LAT(cfj_pkg::cfj_latency(CORDIC_STAGES))
) u_cfj_checker (.*);

// ----- sim/tb_cartesian_force_to_joint_torque.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cartesian_force_to_joint_torque: self-checking bench for the force block
// Drives random and directed force transactions under several register
// settings and compares every result with a bit-exact behavioral predictor.
// ----------------------------------------------------------------------------

typedef struct {
  logic signed [15:0] tau1;
  logic signed [15:0] tau2;
  logic               status;
  logic               flim;
  logic [1:0]         tlim;
} torque_res_t;

class torque_scoreboard;
  torque_res_t pending[$];
  int          errors;
  int          checked;

  function void note(torque_res_t r);
    pending.push_back(r);
  endfunction

  task report(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, checked);
    errors++;
  endtask

  task check(torque_res_t got);
    torque_res_t want;
    if (pending.size() == 0) begin
      report("unexpected result", 1, 0);
      return;
    end
    want = pending.pop_front();
    if (got.tau1 !== want.tau1) report("torque_joint1", got.tau1, want.tau1);
    if (got.tau2 !== want.tau2) report("torque_joint2", got.tau2, want.tau2);
    if (got.status !== want.status) report("status", got.status, want.status);
    if (got.flim !== want.flim) report("force_limited", got.flim, want.flim);
    if (got.tlim !== want.tlim) report("torque_limited", got.tlim, want.tlim);
    checked++;
  endtask
endclass

module tb_cartesian_force_to_joint_torque;
  import cfj_pkg::*;

  localparam int LATENCY = 72;
  localparam int WATCHDOG = 2000;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [23:0] in_force_x = 0, in_force_y = 0;
  logic signed [15:0] in_angle_joint1 = 0, in_angle_joint2 = 0;
  logic signed [15:0] in_speed_joint1 = 0, in_speed_joint2 = 0;
  logic in_friction_on = 0, in_is_calibrated = 0;
  logic cfg_we = 0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic out_valid;
  logic signed [15:0] out_torque_joint1, out_torque_joint2;
  logic out_status, out_force_limited;
  logic [1:0] out_torque_limited;

  cartesian_force_to_joint_torque DUT (.*);

  always #4 clk = ~clk;

  torque_scoreboard sb = new();
  longint unsigned link1, link2, fmax, tmax, coul1, coul2, visc1, visc2;
  int idle_pct = 22;
  int sent;
  int calm_count;

  function automatic longint asr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint atan_entry(int i);
    longint tbl[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
      33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
    return tbl[i];
  endfunction

  task automatic sin_cos(input longint ang, output longint s, output longint c);
    longint x, y, nx;
    bit flip;
    x = 652032874;
    y = 0;
    flip = 0;
    while (ang >= 64'sd3373259426) ang -= 64'sd6746518852;
    while (ang < -64'sd3373259426) ang += 64'sd6746518852;
    if (ang > 64'sd1686629713) begin
      ang -= 64'sd3373259426;
      flip = 1;
    end else if (ang < -64'sd1686629713) begin
      ang += 64'sd3373259426;
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      if (ang >= 0) begin
        nx = x - asr_floor(y, i);
        y = y + asr_floor(x, i);
        ang -= atan_entry(i);
      end else begin
        nx = x + asr_floor(y, i);
        y = y - asr_floor(x, i);
        ang += atan_entry(i);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint scale_force(longint f, longint unsigned lim,
                                         longint unsigned n);
    longint unsigned r;
    if (n == 0) return 0;
    r = ((f < 0 ? -f : f) * lim) / n;
    return f < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint friction(longint tau, longint v, longint unsigned cl,
                                      longint unsigned vs);
    if (v > 61) tau += cl;
    else if (v < -61) tau -= cl;
    else return tau;
    return tau + asr_floor(longint'(vs) * v, 11);
  endfunction

  task automatic predict_torques(output torque_res_t r);
    longint fx, fy, v1, v2, s1, c1, s12, c12, g1, g12, lim;
    longint tau[2];
    longint unsigned sum, n;
    r = '{0, 0, 0, 0, 0};
    if (!in_is_calibrated) begin
      r.status = 1;
      return;
    end
    fx = in_force_x;
    fy = in_force_y;
    v1 = in_speed_joint1;
    v2 = in_speed_joint2;
    sum = fx * fx + fy * fy;
    if (sum > fmax * fmax) begin
      n = int_sqrt(sum);
      fx = scale_force(fx, fmax, n);
      fy = scale_force(fy, fmax, n);
      r.flim = 1;
    end
    sin_cos(longint'(in_angle_joint1) * 131072, s1, c1);
    sin_cos(longint'(in_angle_joint1) * 131072 + longint'(in_angle_joint2) * 131072,
            s12, c12);
    g1 = asr_floor(c1 * fy - s1 * fx, 14);
    g12 = asr_floor(c12 * fy - s12 * fx, 14);
    tau[1] = asr_floor(longint'(link2) * g12, 32);
    tau[0] = asr_floor(longint'(link1) * g1 + longint'(link2) * g12, 32);
    if (in_friction_on) begin
      tau[0] = friction(tau[0], v1, coul1, visc1);
      tau[1] = friction(tau[1], v2, coul2, visc2);
    end
    lim = tmax;
    for (int j = 0; j < 2; j++) begin
      if (tau[j] > lim) begin
        tau[j] = lim;
        r.tlim[j] = 1;
      end else if (tau[j] < -lim) begin
        tau[j] = -lim;
        r.tlim[j] = 1;
      end
    end
    r.tau1 = tau[0][15:0];
    r.tau2 = tau[1][15:0];
  endtask

  // Results are sampled at the edge that ends their strobe cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check('{out_torque_joint1, out_torque_joint2, out_status,
                 out_force_limited, out_torque_limited});
      calm_count <= 0;
    end else if (!(start && !busy)) begin
      calm_count <= calm_count + 1;
    end else begin
      calm_count <= 0;
    end
  end

  always @(posedge clk) begin
    if (calm_count >= WATCHDOG) begin
      $display("watchdog expired");
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, longint unsigned val);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_LINK1:      link1 = val & 16'hFFFF;
      CFG_LINK2:      link2 = val & 16'hFFFF;
      CFG_MAX_FORCE:  fmax = val & 18'h3FFFF;
      CFG_MAX_TORQUE: tmax = val & 15'h7FFF;
      CFG_COUL1:      coul1 = val & 15'h7FFF;
      CFG_COUL2:      coul2 = val & 15'h7FFF;
      CFG_VISC1:      visc1 = val & 16'hFFFF;
      CFG_VISC2:      visc2 = val & 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic setup(longint unsigned l1, longint unsigned l2, longint unsigned mf,
                       longint unsigned mt, longint unsigned c1, longint unsigned c2,
                       longint unsigned w1, longint unsigned w2);
    write_reg(CFG_LINK1, l1);
    write_reg(CFG_LINK2, l2);
    write_reg(CFG_MAX_FORCE, mf);
    write_reg(CFG_MAX_TORQUE, mt);
    write_reg(CFG_COUL1, c1);
    write_reg(CFG_COUL2, c2);
    write_reg(CFG_VISC1, w1);
    write_reg(CFG_VISC2, w2);
  endtask

  // Sends one transaction; start stays high across back-to-back transactions.
  task automatic send(logic signed [23:0] fx, logic signed [23:0] fy,
                      logic signed [15:0] a1, logic signed [15:0] a2,
                      logic signed [15:0] v1, logic signed [15:0] v2,
                      logic fr, logic cal);
    torque_res_t r;
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    in_force_x <= fx;
    in_force_y <= fy;
    in_angle_joint1 <= a1;
    in_angle_joint2 <= a2;
    in_speed_joint1 <= v1;
    in_speed_joint2 <= v2;
    in_friction_on <= fr;
    in_is_calibrated <= cal;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_torques(r);
    sb.note(r);
    sent++;
  endtask

  function automatic logic signed [23:0] rand_force();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(8191)) - 4096);
      2: return 24'($signed($urandom_range(131071)) - 65536);
      default: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_speed();
    case ($urandom_range(2))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(130)) - 65);
      default: return 16'($signed($urandom_range(4095)) - 2048);
    endcase
  endfunction

  task automatic random_block(int count);
    for (int k = 0; k < count; k++) begin
      if (k >= count / 3 && k < count / 2) idle_pct = 0;
      else idle_pct = 22;
      send(rand_force(), rand_force(), 16'($urandom), 16'($urandom), rand_speed(),
           rand_speed(), 1'($urandom_range(1)), $urandom_range(9) != 0);
    end
    idle_pct = 22;
  endtask

  initial begin
    link1 = 0; link2 = 0; fmax = 0; tmax = 0;
    coul1 = 0; coul2 = 0; visc1 = 0; visc2 = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Reset values: zero limits, everything clamps to zero.
    send(24'sd1000, -24'sd500, 0, 0, 0, 0, 0, 1);
    send(0, 0, 0, 0, 0, 0, 1, 1);
    drain();

    setup(40000, 30000, 25600, 20480, 512, 768, 300, 900);
    send(24'sh7FFFFF, 24'sh7FFFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1, 1);
    send(24'sh800000, 24'sh800000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1, 1);
    send(24'sh800000, 0, 16'sh8000, 16'sh7FFF, 62, -62, 1, 1);
    send(0, 24'sh7FFFFF, 12868, -12868, 61, -61, 1, 1);
    send(2560, -2560, 0, 0, 100, 100, 0, 1);
    send(2560, 2560, 6434, 6434, -100, 100, 1, 0);
    send(-300, 700, 25736, -25736, 0, 0, 1, 1);
    // Sender waits for every outstanding result before continuing.
    drain();

    setup(65535, 65535, 0, 32767, 32767, 32767, 65535, 65535);
    send(1, -1, 100, 200, 16'sh7FFF, 16'sh8000, 1, 1);
    send(0, 0, 100, 200, 16'sh7FFF, 16'sh8000, 1, 1);
    random_block(150);
    drain();

    setup(50000, 40000, 262143, 20480, 1000, 2000, 5000, 4000);
    random_block(500);
    drain();

    setup(12000, 9000, 6400, 4000, 256, 128, 512, 1024);
    random_block(500);
    drain();

    setup($urandom_range(65535), $urandom_range(65535), $urandom_range(262143),
          $urandom_range(20480), $urandom_range(20480), $urandom_range(20480),
          $urandom_range(65535), $urandom_range(65535));
    random_block(150);
    drain();

    $display("Sent %0d transactions over five register settings, %0d results checked.",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
